>>> sv/mfde_pkg.sv
// Shared types and constants for the framebuffer draw engine.
package mfde_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 64;
  localparam int unsigned STORE_DEPTH       = 1024;
  localparam int unsigned ADDR_W            = 10;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_PIXEL  = 3'd0,
    REQ_LINE   = 3'd1,
    REQ_RECT   = 3'd2,
    REQ_FILL   = 3'd3,
    REQ_SCREEN = 3'd4,
    REQ_READ   = 3'd5
  } req_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic [2:0] req;
    logic [6:0] x_a;
    logic [5:0] y_a;
    logic [6:0] x_b;
    logic [5:0] y_b;
    logic [7:0] w;
    logic [6:0] h;
    logic       val;
    logic [9:0] idx;
  } cmd_t;

endpackage

>>> sv/mfde_front.sv
// Front end: accepts commands and queues them for the back end.
module mfde_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mfde_pkg::cmd_t cmd_i,
  output logic           busy_o,
  output logic           q_valid_o,
  output mfde_pkg::cmd_t q_cmd_o,
  input  logic           q_pop_i
);

  // Two-entry queue.
  mfde_pkg::cmd_t mem_q [2];
  logic           wp_q, rp_q, wp_d, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ q_pop_i;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

endmodule

>>> sv/mfde_back.sv
// Back end: walks pixels of each command with read-modify-write on the store.
module mfde_back #(
  parameter int unsigned SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  mfde_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           done_o,
  output logic [7:0]     read_data_o
);

  localparam int unsigned PAGES = SCREEN_HEIGHT / 8;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_GEN   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_RDOUT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] mem_q [mfde_pkg::STORE_DEPTH];
  logic [7:0] rd_q;

  // Walk registers (signed 10 bit covers all coordinates and errors).
  mfde_pkg::cmd_t cmd_q, cmd_d;
  logic signed [9:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [9:0] err_q, err_d;
  logic signed [9:0] dx_q, dy_q, sx_q, sy_q;
  logic [1:0]        ph_q, ph_d;
  logic              last_q, last_d;
  logic [9:0]        clr_q, clr_d;
  logic [9:0]        paddr_q, paddr_d;
  logic [7:0]        pmask_q, pmask_d;
  logic              pvld_q, pvld_d;

  logic signed [9:0] x1, y1, tw, xr, yb;
  logic signed [9:0] px, py;
  logic              pon, pend;
  logic signed [15:0] addr_w;

  assign x1 = $signed({3'b0, cmd_q.x_b});
  assign y1 = $signed({4'b0, cmd_q.y_b});
  assign tw = err_q <<< 1;

  // A screen fill spans the whole configured screen; rectangles span their own size.
  assign xr = (cmd_q.req == mfde_pkg::REQ_SCREEN) ? $signed(10'(SCREEN_WIDTH - 1)) :
              $signed({3'b0, cmd_q.x_a}) + $signed({2'b0, cmd_q.w}) - 10'sd1;
  assign yb = (cmd_q.req == mfde_pkg::REQ_SCREEN) ? $signed(10'(SCREEN_HEIGHT - 1)) :
              $signed({4'b0, cmd_q.y_a}) + $signed({3'b0, cmd_q.h}) - 10'sd1;

  // Choose the next pixel to plot and advance the walk.
  always_comb begin
    cx_d = cx_q; cy_d = cy_q; err_d = err_q; ph_d = ph_q; last_d = last_q;
    px = cx_q; py = cy_q; pon = 1'b1; pend = 1'b0;
    case (cmd_q.req)
      mfde_pkg::REQ_PIXEL: begin
        pend = 1'b1;
      end
      mfde_pkg::REQ_LINE: begin
        if (cx_q == x1 && cy_q == y1) begin
          pend = 1'b1;
        end else begin
          if (tw > -dy_q) begin
            err_d = err_d - dy_q;
            cx_d  = cx_q + sx_q;
          end
          if (tw < dx_q) begin
            err_d = err_d + dx_q;
            cy_d  = cy_q + sy_q;
          end
        end
      end
      mfde_pkg::REQ_RECT: begin
        // Phases: top row, bottom row, left column, right column.
        case (ph_q)
          2'd0: py = $signed({4'b0, cmd_q.y_a});
          2'd1: py = yb;
          2'd2: px = $signed({3'b0, cmd_q.x_a});
          default: px = xr;
        endcase
        if (ph_q[1] == 1'b0) begin
          if (cx_q == xr) begin
            cx_d = $signed({3'b0, cmd_q.x_a});
            ph_d = ph_q + 2'd1;
            if (ph_q == 2'd1) cy_d = $signed({4'b0, cmd_q.y_a});
          end else begin
            cx_d = cx_q + 10'sd1;
          end
        end else begin
          if (cy_q == yb) begin
            cy_d = $signed({4'b0, cmd_q.y_a});
            ph_d = ph_q + 2'd1;
            pend = (ph_q == 2'd3);
          end else begin
            cy_d = cy_q + 10'sd1;
          end
        end
        pon = (cmd_q.w != 8'd0) && (cmd_q.h != 7'd0);
        if (!pon) pend = 1'b1;
      end
      mfde_pkg::REQ_FILL, mfde_pkg::REQ_SCREEN: begin
        if (cy_q == yb) begin
          cy_d = $signed({4'b0, cmd_q.y_a});
          if (cx_q == xr) pend = 1'b1;
          else cx_d = cx_q + 10'sd1;
        end else begin
          cy_d = cy_q + 10'sd1;
        end
        pon = (cmd_q.w != 8'd0) && (cmd_q.h != 7'd0);
        if (!pon) pend = 1'b1;
      end
      default: begin
        pend = 1'b1;
        pon  = 1'b0;
      end
    endcase
    if (px < 0 || py < 0 || px >= $signed(10'(SCREEN_WIDTH)) ||
        py >= $signed(10'(SCREEN_HEIGHT))) begin
      pon = 1'b0;
    end
  end

  assign addr_w = 16'(px) * 16'(PAGES) + 16'(py >>> 3);

  // Control sequencer.
  always_comb begin
    state_d = state_q; cmd_d = cmd_q; clr_d = clr_q;
    paddr_d = paddr_q; pmask_d = pmask_q; pvld_d = pvld_q;
    q_pop_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 10'd1;
        if (clr_q == 10'(mfde_pkg::STORE_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          if (q_cmd_i.req == mfde_pkg::REQ_SCREEN) begin
            cmd_d.x_a = 7'd0;
            cmd_d.y_a = 6'd0;
            cmd_d.w   = 8'd1;
            cmd_d.h   = 7'd1;
          end
          state_d = (q_cmd_i.req == mfde_pkg::REQ_READ) ? S_RDOUT : S_GEN;
        end
      end
      S_GEN: begin
        paddr_d = addr_w[9:0];
        pmask_d = 8'd1 << py[2:0];
        pvld_d  = pon && (addr_w < 16'sd1024);
        state_d = S_READ;
      end
      S_READ: state_d = S_WRITE;
      S_WRITE: state_d = last_q ? S_DONE : S_GEN;
      S_RDOUT: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic walk_en, init_en;
  assign walk_en = (state_q == S_GEN);
  assign init_en = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= 10'd0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (walk_en) last_q <= pend;
      else if (init_en) last_q <= 1'b0;
    end
  end

  logic signed [9:0] ix, iy, ix1, iy1, idx0, idy0;
  assign ix   = $signed({3'b0, q_cmd_i.x_a});
  assign iy   = $signed({4'b0, q_cmd_i.y_a});
  assign ix1  = $signed({3'b0, q_cmd_i.x_b});
  assign iy1  = $signed({4'b0, q_cmd_i.y_b});
  assign idx0 = (ix1 > ix) ? ix1 - ix : ix - ix1;
  assign idy0 = (iy1 > iy) ? iy1 - iy : iy - iy1;

  // Line deltas and step directions are fixed for the whole walk.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; paddr_q <= paddr_d; pmask_q <= pmask_d;
    pvld_q <= pvld_d;
    if (init_en) begin
      cx_q  <= (q_cmd_i.req == mfde_pkg::REQ_SCREEN) ? 10'sd0 : ix;
      cy_q  <= (q_cmd_i.req == mfde_pkg::REQ_SCREEN) ? 10'sd0 : iy;
      err_q <= idx0 - idy0;
      dx_q  <= idx0;
      dy_q  <= idy0;
      sx_q  <= (ix < ix1) ? 10'sd1 : -10'sd1;
      sy_q  <= (iy < iy1) ? 10'sd1 : -10'sd1;
      ph_q  <= 2'd0;
    end else if (walk_en) begin
      cx_q <= cx_d; cy_q <= cy_d; err_q <= err_d; ph_q <= ph_d;
    end
  end

  // Store: one read port, one write port.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      mem_q[clr_q] <= 8'd0;
    end else if (state_q == S_WRITE && pvld_q) begin
      mem_q[paddr_q] <= cmd_q.val ? (rd_q | pmask_q) : (rd_q & ~pmask_q);
    end
    rd_q <= mem_q[(state_q == S_IDLE)  ? q_cmd_i.idx :
                  (state_q == S_RDOUT) ? cmd_q.idx   : paddr_q];
  end

  assign done_o      = (state_q == S_DONE);
  assign read_data_o = (cmd_q.req == mfde_pkg::REQ_READ) ? rd_q : 8'd0;

endmodule

>>> sv/mono_framebuffer_draw_engine.sv
// Top level of the monochrome framebuffer draw engine.
// Each command gives one result strobe (done_o) with read_data_o; the receiver cannot stall.
// A command takes each plotted pixel through the store's read-modify-write port in the
// states S_GEN, S_READ and S_WRITE, one pixel at a time; a read goes through S_RDOUT.
// After reset all 1024 bytes of the store are cleared before the first command runs; up to two
// commands queue meanwhile, and busy rises when the queue is full.
module mono_framebuffer_draw_engine #(
  parameter int unsigned SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type_i,
  input  logic [6:0] x_a_i,
  input  logic [5:0] y_a_i,
  input  logic [6:0] x_b_i,
  input  logic [5:0] y_b_i,
  input  logic [7:0] rect_width_i,
  input  logic [6:0] rect_height_i,
  input  logic       draw_value_i,
  input  logic [9:0] read_index_i,
  output logic       done_o,
  output logic [7:0] read_data_o
);

  mfde_pkg::cmd_t cmd, q_cmd;
  logic           q_valid, q_pop;

  assign cmd = '{req: req_type_i, x_a: x_a_i, y_a: y_a_i, x_b: x_b_i, y_b: y_b_i,
                 w: rect_width_i, h: rect_height_i, val: draw_value_i, idx: read_index_i};

  mfde_front u_front (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(cmd), .busy_o(busy),
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  mfde_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .done_o, .read_data_o
  );

endmodule
